// ===== rtl/ius_pkg.sv =====
// ----------------------------------------------------------------------------
// ius_pkg
// Shared widths, request codes and types for the interval union/difference core.
// ----------------------------------------------------------------------------
`default_nettype none

package ius_pkg;

  localparam int TIME_W            = 64;
  localparam int MAX_INTERVALS_DEF = 32;
  localparam int OPCODE_W          = 2;
  localparam int IN_TDATA_W        = 136;
  localparam int OUT_TDATA_W       = 128;
  localparam int OUT_TUSER_W       = 2;

  localparam logic [OPCODE_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RUN    = 2'd2;

  typedef logic [TIME_W-1:0] time_t;

  typedef struct packed {
    time_t span_end;
    time_t span_start;
  } span_t;

  typedef struct packed {
    time_t x;
    time_t y;
  } cmp_req_t;

  typedef struct packed {
    logic  lt;
    time_t mx;
  } cmp_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ius_ram.sv =====
// ----------------------------------------------------------------------------
// ius_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ius_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ius_cmp.sv =====
// ----------------------------------------------------------------------------
// ius_cmp
// Shared 64-bit compare unit: less-than flag and maximum of two operands.
// ----------------------------------------------------------------------------
`default_nettype none

module ius_cmp (
  input  wire ius_pkg::cmp_req_t req,
  output      ius_pkg::cmp_rsp_t rsp
);

  import ius_pkg::*;

  logic lt;

  assign lt     = req.x < req.y;
  assign rsp.lt = lt;
  assign rsp.mx = lt ? req.y : req.x;

endmodule

`default_nettype wire

// ===== rtl/interval_union_difference_core.sv =====
// ----------------------------------------------------------------------------
// interval_union_difference_core
// Loads two interval lists with union on load; a run request sweeps both
// lists and streams the pieces of A not covered by B, then clears them.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                               | tuser / tlast
//  in_     | in  | opcode, span_start, span_end        | -
//  out_    | out | piece_start, piece_end              | empty_result, overflow / last
//
//  Load requests and run sweep steps are paced by the single shared 64-bit
//  compare unit and the registered reads of the list RAMs. in_tready is high
//  only when idle. Reset (rst_n, synchronous) empties both lists and the
//  overflow flag. A stalled output holds the sweep only when a second piece
//  is ready, and holds the finish until the final piece can be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_union_difference_core #(
  parameter int MAX_INTERVALS = ius_pkg::MAX_INTERVALS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  input  wire logic [ius_pkg::IN_TDATA_W-1:0]     in_tdata,  // opcode, span_start, span_end
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  output      logic [ius_pkg::OUT_TDATA_W-1:0]    out_tdata, // piece_start, piece_end
  output      logic                               out_tlast,
  output      logic [ius_pkg::OUT_TUSER_W-1:0]    out_tuser  // empty_result, overflow
);

  import ius_pkg::*;

  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INTERVALS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_LD_CMP   = 5'd1;
  localparam logic [4:0] S_LD_MAX   = 5'd2;
  localparam logic [4:0] S_CP_RD    = 5'd3;
  localparam logic [4:0] S_CP_EMIT  = 5'd4;
  localparam logic [4:0] S_SW_START = 5'd5;
  localparam logic [4:0] S_SW_FIRST = 5'd6;
  localparam logic [4:0] S_RD_A     = 5'd7;
  localparam logic [4:0] S_RD_B     = 5'd8;
  localparam logic [4:0] S_T_SKIP   = 5'd9;
  localparam logic [4:0] S_R1       = 5'd10;
  localparam logic [4:0] S_R1_DONE  = 5'd11;
  localparam logic [4:0] S_R1_MAX   = 5'd12;
  localparam logic [4:0] S_R1_EMIT  = 5'd13;
  localparam logic [4:0] S_R2A      = 5'd14;
  localparam logic [4:0] S_R2B      = 5'd15;
  localparam logic [4:0] S_R3       = 5'd16;
  localparam logic [4:0] S_R3_DONE  = 5'd17;
  localparam logic [4:0] S_R3_MAX   = 5'd18;
  localparam logic [4:0] S_R3_EMIT  = 5'd19;
  localparam logic [4:0] S_R4       = 5'd20;
  localparam logic [4:0] S_TL_RD    = 5'd21;
  localparam logic [4:0] S_TL_MAX   = 5'd22;
  localparam logic [4:0] S_TL_EMIT  = 5'd23;
  localparam logic [4:0] S_FIN      = 5'd24;

  logic [4:0]       state_r, state_nxt;
  logic [CNT_W-1:0] ca_r, ca_nxt, cb_r, cb_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic             ovf_r, ovf_nxt;
  logic             lsel_r, lsel_nxt;
  time_t            lds_r, lds_nxt, lde_r, lde_nxt;
  time_t            las_r, las_nxt, lae_r, lae_nxt;
  time_t            lbs_r, lbs_nxt, lbe_r, lbe_nxt;
  time_t            done_r, done_nxt, rs_r, rs_nxt;
  logic             ge_r, ge_nxt;
  logic             pend_v_r, pend_v_nxt;
  time_t            pend_s_r, pend_s_nxt, pend_e_r, pend_e_nxt;
  logic             out_v_r, out_v_nxt;
  time_t            out_s_r, out_s_nxt, out_e_r, out_e_nxt;
  logic             out_last_r, out_last_nxt, out_empty_r, out_empty_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic [OPCODE_W-1:0] in_op;
  logic                in_acc;
  cmp_req_t            creq;
  cmp_rsp_t            crsp;
  span_t               qa, qb, wdata;
  logic                we, re_a, re_b;
  logic [IDX_W-1:0]    waddr, ra_addr, rb_addr;
  logic [CNT_W-1:0]    cnt_sel, cnt_m1, i_inc, j_inc;
  time_t               lend, lstart, as_w, ae_w, bs_w, be_w;
  logic                out_free, emit_req, stall, push;
  time_t               emit_s, emit_e;

  assign in_op    = in_tdata[OPCODE_W-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;

  assign as_w = qa.span_start;
  assign ae_w = qa.span_end;
  assign bs_w = qb.span_start;
  assign be_w = qb.span_end;

  assign cnt_sel = lsel_r ? cb_r : ca_r;
  assign cnt_m1  = cnt_sel - CNT_ONE;
  assign lend    = lsel_r ? lbe_r : lae_r;
  assign lstart  = lsel_r ? lbs_r : las_r;
  assign i_inc   = i_r + CNT_ONE;
  assign j_inc   = j_r + CNT_ONE;

  ius_ram #(.WIDTH($bits(span_t)), .DEPTH(MAX_INTERVALS)) u_ram_a (
    .clk   (clk),
    .we    (we && !lsel_r),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re_a),
    .raddr (ra_addr),
    .rdata (qa)
  );

  ius_ram #(.WIDTH($bits(span_t)), .DEPTH(MAX_INTERVALS)) u_ram_b (
    .clk   (clk),
    .we    (we && lsel_r),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re_b),
    .raddr (rb_addr),
    .rdata (qb)
  );

  ius_cmp u_cmp (
    .req (creq),
    .rsp (crsp)
  );

  always_comb begin
    creq = '0;
    case (state_r)
      S_LD_CMP:  begin creq.x = lend;   creq.y = lds_r;  end
      S_LD_MAX:  begin creq.x = lend;   creq.y = lde_r;  end
      S_T_SKIP:  begin creq.x = as_w;   creq.y = be_w;   end
      S_R1:      begin creq.x = bs_w;   creq.y = ae_w;   end
      S_R1_DONE: begin creq.x = ae_w;   creq.y = done_r; end
      S_R1_MAX:  begin creq.x = done_r; creq.y = as_w;   end
      S_R1_EMIT: begin creq.x = rs_r;   creq.y = ae_w;   end
      S_R2A:     begin creq.x = as_w;   creq.y = bs_w;   end
      S_R2B:     begin creq.x = be_w;   creq.y = ae_w;   end
      S_R3:      begin creq.x = bs_w;   creq.y = as_w;   end
      S_R3_DONE: begin creq.x = bs_w;   creq.y = done_r; end
      S_R3_MAX:  begin creq.x = done_r; creq.y = as_w;   end
      S_R3_EMIT: begin creq.x = rs_r;   creq.y = bs_w;   end
      S_R4:      begin creq.x = be_w;   creq.y = as_w;   end
      S_TL_MAX:  begin creq.x = as_w;   creq.y = done_r; end
      S_TL_EMIT: begin creq.x = rs_r;   creq.y = ae_w;   end
      default:   creq = '0;
    endcase
  end

  always_comb begin
    emit_req = 1'b0;
    emit_s   = rs_r;
    emit_e   = ae_w;
    case (state_r)
      S_CP_EMIT: begin
        emit_req = 1'b1;
        emit_s   = as_w;
      end
      S_R1_EMIT, S_TL_EMIT: emit_req = crsp.lt;
      S_R3_EMIT: begin
        emit_req = crsp.lt;
        emit_e   = bs_w;
      end
      default: emit_req = 1'b0;
    endcase
  end

  assign out_free = !out_v_r || out_tready;
  assign stall    = emit_req && pend_v_r && !out_free;
  assign push     = (emit_req && pend_v_r && out_free) || (state_r == S_FIN && out_free);

  always_comb begin
    state_nxt  = state_r;
    ca_nxt     = ca_r;
    cb_nxt     = cb_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    ovf_nxt    = ovf_r;
    lsel_nxt   = lsel_r;
    lds_nxt    = lds_r;
    lde_nxt    = lde_r;
    las_nxt    = las_r;
    lae_nxt    = lae_r;
    lbs_nxt    = lbs_r;
    lbe_nxt    = lbe_r;
    done_nxt   = done_r;
    rs_nxt     = rs_r;
    ge_nxt     = ge_r;
    pend_v_nxt = pend_v_r;
    pend_s_nxt = pend_s_r;
    pend_e_nxt = pend_e_r;
    we         = 1'b0;
    waddr      = cnt_sel[IDX_W-1:0];
    wdata      = {lde_r, lds_r};
    re_a       = 1'b0;
    re_b       = 1'b0;
    ra_addr    = i_r[IDX_W-1:0];
    rb_addr    = j_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_LOAD_A, OP_LOAD_B: begin
              lsel_nxt  = in_op[0];
              lds_nxt   = in_tdata[OPCODE_W +: TIME_W];
              lde_nxt   = in_tdata[OPCODE_W + TIME_W +: TIME_W];
              state_nxt = S_LD_CMP;
            end
            OP_RUN: begin
              i_nxt = '0;
              j_nxt = '0;
              if (ca_r == '0) begin
                state_nxt = S_FIN;
              end else if (cb_r == '0) begin
                state_nxt = S_CP_RD;
              end else begin
                state_nxt = S_SW_START;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LD_CMP: begin
        if (cnt_sel != '0 && !crsp.lt) begin
          state_nxt = S_LD_MAX;
        end else if (cnt_sel == CNT_MAX) begin
          ovf_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          we = 1'b1;
          if (lsel_r) begin
            lbs_nxt = lds_r;
            lbe_nxt = lde_r;
            cb_nxt  = cb_r + CNT_ONE;
          end else begin
            las_nxt = lds_r;
            lae_nxt = lde_r;
            ca_nxt  = ca_r + CNT_ONE;
          end
          state_nxt = S_IDLE;
        end
      end
      S_LD_MAX: begin
        we    = 1'b1;
        waddr = cnt_m1[IDX_W-1:0];
        wdata = {crsp.mx, lstart};
        if (lsel_r) begin
          lbe_nxt = crsp.mx;
        end else begin
          lae_nxt = crsp.mx;
        end
        state_nxt = S_IDLE;
      end
      S_CP_RD: begin
        if (i_r == ca_r) begin
          state_nxt = S_FIN;
        end else begin
          re_a      = 1'b1;
          state_nxt = S_CP_EMIT;
        end
      end
      S_CP_EMIT: begin
        if (!stall) begin
          i_nxt     = i_inc;
          state_nxt = S_CP_RD;
        end
      end
      S_SW_START: begin
        re_a      = 1'b1;
        state_nxt = S_SW_FIRST;
      end
      S_SW_FIRST: begin
        done_nxt  = as_w;
        re_b      = 1'b1;
        state_nxt = S_T_SKIP;
      end
      S_RD_A: begin
        re_a      = 1'b1;
        state_nxt = S_T_SKIP;
      end
      S_RD_B: begin
        re_b      = 1'b1;
        state_nxt = S_T_SKIP;
      end
      S_T_SKIP: begin
        if (crsp.lt) begin
          state_nxt = S_R1;
        end else begin
          j_nxt     = j_inc;
          state_nxt = (j_inc == cb_r) ? S_TL_RD : S_RD_B;
        end
      end
      S_R1: begin
        state_nxt = crsp.lt ? S_R2A : S_R1_DONE;
      end
      S_R1_DONE: begin
        if (crsp.lt) begin
          i_nxt     = i_inc;
          state_nxt = (i_inc == ca_r) ? S_TL_RD : S_RD_A;
        end else begin
          state_nxt = S_R1_MAX;
        end
      end
      S_R1_MAX: begin
        rs_nxt    = crsp.mx;
        state_nxt = S_R1_EMIT;
      end
      S_R1_EMIT: begin
        if (!stall) begin
          done_nxt  = ae_w;
          i_nxt     = i_inc;
          state_nxt = (i_inc == ca_r) ? S_TL_RD : S_RD_A;
        end
      end
      S_R2A: begin
        ge_nxt    = !crsp.lt;
        state_nxt = S_R2B;
      end
      S_R2B: begin
        if (ge_r && !crsp.lt) begin
          i_nxt     = i_inc;
          state_nxt = (i_inc == ca_r) ? S_TL_RD : S_RD_A;
        end else begin
          state_nxt = S_R3;
        end
      end
      S_R3: begin
        state_nxt = crsp.lt ? S_R4 : S_R3_DONE;
      end
      S_R3_DONE: begin
        if (crsp.lt) begin
          j_nxt     = j_inc;
          state_nxt = (j_inc == cb_r) ? S_TL_RD : S_RD_B;
        end else begin
          state_nxt = S_R3_MAX;
        end
      end
      S_R3_MAX: begin
        rs_nxt    = crsp.mx;
        state_nxt = S_R3_EMIT;
      end
      S_R3_EMIT: begin
        if (!stall) begin
          done_nxt  = be_w;
          j_nxt     = j_inc;
          state_nxt = (j_inc == cb_r) ? S_TL_RD : S_RD_B;
        end
      end
      S_R4: begin
        if (!crsp.lt) begin
          done_nxt  = be_w;
          j_nxt     = j_inc;
          state_nxt = (j_inc == cb_r) ? S_TL_RD : S_RD_B;
        end else begin
          i_nxt     = i_inc;
          state_nxt = (i_inc == ca_r) ? S_TL_RD : S_RD_A;
        end
      end
      S_TL_RD: begin
        if (i_r == ca_r) begin
          state_nxt = S_FIN;
        end else begin
          re_a      = 1'b1;
          state_nxt = S_TL_MAX;
        end
      end
      S_TL_MAX: begin
        rs_nxt    = crsp.mx;
        state_nxt = S_TL_EMIT;
      end
      S_TL_EMIT: begin
        if (!stall) begin
          done_nxt  = ae_w;
          i_nxt     = i_inc;
          state_nxt = S_TL_RD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          ca_nxt     = '0;
          cb_nxt     = '0;
          ovf_nxt    = 1'b0;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (emit_req && !stall) begin
      pend_v_nxt = 1'b1;
      pend_s_nxt = emit_s;
      pend_e_nxt = emit_e;
    end
  end

  always_comb begin
    out_v_nxt     = out_v_r;
    out_s_nxt     = out_s_r;
    out_e_nxt     = out_e_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;
    if (push) begin
      out_v_nxt     = 1'b1;
      out_s_nxt     = pend_v_r ? pend_s_r : '0;
      out_e_nxt     = pend_v_r ? pend_e_r : '0;
      out_last_nxt  = (state_r == S_FIN);
      out_empty_nxt = !pend_v_r;
      out_ovf_nxt   = ovf_r;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ca_r     <= '0;
      cb_r     <= '0;
      ovf_r    <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ca_r     <= ca_nxt;
      cb_r     <= cb_nxt;
      ovf_r    <= ovf_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    lsel_r      <= lsel_nxt;
    lds_r       <= lds_nxt;
    lde_r       <= lde_nxt;
    las_r       <= las_nxt;
    lae_r       <= lae_nxt;
    lbs_r       <= lbs_nxt;
    lbe_r       <= lbe_nxt;
    done_r      <= done_nxt;
    rs_r        <= rs_nxt;
    ge_r        <= ge_nxt;
    pend_s_r    <= pend_s_nxt;
    pend_e_r    <= pend_e_nxt;
    out_s_r     <= out_s_nxt;
    out_e_r     <= out_e_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_e_r, out_s_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ovf_r, out_empty_r};

endmodule

`default_nettype wire

// ===== rtl/ius_chk.sv =====
// ----------------------------------------------------------------------------
// ius_chk
// Port-level checks for the interval union/difference core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ius_chk (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [ius_pkg::IN_TDATA_W-1:0]  in_tdata,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [ius_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                            out_tlast,
  input wire logic [ius_pkg::OUT_TUSER_W-1:0] out_tuser
);

  import ius_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
    && $stable(out_tuser))
    else $error("stalled result changed");

  a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && (out_tdata == '0))
    else $error("empty result is not a lone zero final");

  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("request taken while a run is still in progress");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[OPCODE_W-1:0] == OP_LOAD_A
    || in_tdata[OPCODE_W-1:0] == OP_LOAD_B || in_tdata[OPCODE_W-1:0] == OP_RUN)
    |=> !in_tready)
    else $error("ready right after a load or run request");

endmodule

bind interval_union_difference_core ius_chk u_ius_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
